FILE: src/bsss_pkg.sv
// ----------------------------------------------------------------------------
// bsss_pkg: shared types and constants for the segment velocity sum
// widths of the fixed point datapath, payload structs, queue record and
// register indexes
// ----------------------------------------------------------------------------
package bsss_pkg;

    localparam int COORD_FRAC_BITS_DEF = 20;
    localparam int QUEUE_DEPTH_DEF     = 2;

    localparam int CoordW    = 32;
    localparam int DiffW     = 33;
    localparam int NormLimit = 16384;
    localparam int NormW     = 15;
    localparam int SqW       = 30;
    localparam int RootW     = 15;
    localparam int DotW      = 31;
    localparam int CrossW    = 30;
    localparam int CrossMagW = 29;
    localparam int PsumW     = 16;
    localparam int NumW      = 45;
    localparam int DenW      = 61;
    localparam int ProdW     = 77;
    localparam int DivW      = 128;
    localparam int GuardBits = 48;
    localparam int ContribW  = 42;
    localparam int AccW      = 64;
    localparam int NormShW   = 5;
    localparam int ShW       = 9;
    localparam int MantW     = 32;
    localparam int CoeffShW  = 6;
    localparam int CfgAddrW  = 2;

    // register indexes of the configuration port
    localparam logic [CfgAddrW-1:0] CFG_COEFF_MANTISSA = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_COEFF_SHIFT    = 2'd1;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
        logic signed [CoordW-1:0] seg_start_x;
        logic signed [CoordW-1:0] seg_start_y;
        logic signed [CoordW-1:0] seg_start_z;
        logic signed [CoordW-1:0] seg_end_x;
        logic signed [CoordW-1:0] seg_end_y;
        logic signed [CoordW-1:0] seg_end_z;
        logic                     excluded;
        logic                     last_segment;
    } in_t;

    typedef struct packed {
        logic signed [CoordW-1:0] vel_x;
        logic signed [CoordW-1:0] vel_y;
        logic signed [CoordW-1:0] vel_z;
        logic                     overflow;
    } out_t;

    // classified segment handed from front to back
    typedef struct packed {
        logic                       excl;
        logic                       last;
        logic                       zero;
        logic [NormShW-1:0]         s;
        logic [DenW-1:0]            d;
        logic [2:0][NumW-1:0]       n;
        logic [2:0]                 neg;
    } job_t;

    function automatic logic [DiffW-1:0] mag33(input logic signed [DiffW-1:0] v);
        mag33 = v[DiffW-1] ? DiffW'(-v) : DiffW'(v);
    endfunction

endpackage

FILE: src/bsss_front.sv
// ----------------------------------------------------------------------------
// bsss_front: segment geometry sequencer
// takes one request, forms the normalized relative vectors, their lengths,
// dot and cross products, denominator and numerators, then queues the job
// ----------------------------------------------------------------------------
module bsss_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bsss_pkg::in_t  s_data,
    output logic           q_push,
    input  logic           q_full,
    output bsss_pkg::job_t q_data
);

    localparam logic [3:0] F_IDLE  = 4'd0;
    localparam logic [3:0] F_MAX   = 4'd1;
    localparam logic [3:0] F_NORM  = 4'd2;
    localparam logic [3:0] F_SCALE = 4'd3;
    localparam logic [3:0] F_PROD  = 4'd4;
    localparam logic [3:0] F_CROSS = 4'd5;
    localparam logic [3:0] F_SQRT  = 4'd6;
    localparam logic [3:0] F_DEN   = 4'd7;
    localparam logic [3:0] F_DEN2  = 4'd8;
    localparam logic [3:0] F_NUM   = 4'd9;
    localparam logic [3:0] F_PUSH  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] cnt_reg;

    logic signed [bsss_pkg::DiffW-1:0]  a_reg [3];
    logic signed [bsss_pkg::DiffW-1:0]  b_reg [3];
    logic [bsss_pkg::DiffW-1:0]         m_reg;
    logic [bsss_pkg::NormShW-1:0]       s_reg;
    logic signed [bsss_pkg::NormW-1:0]  an_reg [3];
    logic signed [bsss_pkg::NormW-1:0]  bn_reg [3];
    logic [bsss_pkg::SqW-1:0]           sqa_reg, sqb_reg;
    logic signed [bsss_pkg::DotW-1:0]   dot_reg;
    logic signed [bsss_pkg::CrossW-1:0] cr_reg [3];
    logic [bsss_pkg::RootW-1:0]         p_reg, q_reg;
    logic [bsss_pkg::SqW-1:0]           pq_reg;
    logic [bsss_pkg::PsumW-1:0]         psum_reg;
    logic [bsss_pkg::DenW-1:0]          d_reg;
    logic [2:0][bsss_pkg::NumW-1:0]     n_reg;
    logic [2:0]                         neg_reg;
    logic                               excl_reg, last_reg, zero_reg;

    logic [1:0] k_idx, k1, k2;
    logic [bsss_pkg::DiffW-1:0] mag_a [3];
    logic [bsss_pkg::DiffW-1:0] mag_b [3];
    logic [bsss_pkg::DiffW-1:0] max_ab [3];
    logic [bsss_pkg::DiffW-1:0] max01, max_all;
    logic signed [2*bsss_pkg::NormW-1:0] sq_a, sq_b, ab_prod, cr_p1, cr_p2;
    logic signed [bsss_pkg::CrossW:0]    cr_diff;
    logic [bsss_pkg::RootW-1:0]          bitv, trial_p, trial_q;
    logic [2*bsss_pkg::RootW-1:0]        tp_sq, tq_sq;
    logic signed [bsss_pkg::CoordW-1:0]  e_val;
    logic                                zero_det;
    logic [bsss_pkg::CrossMagW-1:0]      cr_mag;

    assign s_ready = (state_reg == F_IDLE);
    assign q_push  = (state_reg == F_PUSH) && !q_full;
    assign k_idx   = cnt_reg[1:0];

    // cyclic neighbors for the cross product
    always_comb begin
        case (k_idx)
            2'd0: begin k1 = 2'd1; k2 = 2'd2; end
            2'd1: begin k1 = 2'd2; k2 = 2'd0; end
            default: begin k1 = 2'd0; k2 = 2'd1; end
        endcase
    end

    // largest magnitude of the six differences
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag_a[k]  = bsss_pkg::mag33(a_reg[k]);
            mag_b[k]  = bsss_pkg::mag33(b_reg[k]);
            max_ab[k] = (mag_a[k] > mag_b[k]) ? mag_a[k] : mag_b[k];
        end
        max01   = (max_ab[0] > max_ab[1]) ? max_ab[0] : max_ab[1];
        max_all = (max01 > max_ab[2]) ? max01 : max_ab[2];
    end

    // per-index products
    always_comb begin
        sq_a    = an_reg[k_idx] * an_reg[k_idx];
        sq_b    = bn_reg[k_idx] * bn_reg[k_idx];
        ab_prod = an_reg[k_idx] * bn_reg[k_idx];
        cr_p1   = an_reg[k1] * bn_reg[k2];
        cr_p2   = an_reg[k2] * bn_reg[k1];
        cr_diff = (bsss_pkg::CrossW+1)'(cr_p1) - (bsss_pkg::CrossW+1)'(cr_p2);
    end

    // one root bit per cycle for both lengths
    always_comb begin
        bitv    = bsss_pkg::RootW'(1) << cnt_reg;
        trial_p = p_reg | bitv;
        trial_q = q_reg | bitv;
        tp_sq   = trial_p * trial_p;
        tq_sq   = trial_q * trial_q;
    end

    // denominator terms
    always_comb begin
        e_val    = $signed({2'b00, pq_reg}) + bsss_pkg::CoordW'(dot_reg);
        zero_det = (p_reg == '0) || (q_reg == '0) || (e_val <= 0);
        cr_mag   = cr_reg[k_idx][bsss_pkg::CrossW-1] ?
                   bsss_pkg::CrossMagW'(-cr_reg[k_idx]) : bsss_pkg::CrossMagW'(cr_reg[k_idx]);
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        excl_reg <= s_data.excluded;
                        last_reg <= s_data.last_segment;
                        zero_reg <= 1'b0;
                        a_reg[0] <= $signed({s_data.seg_start_x[31], s_data.seg_start_x})
                                  - $signed({s_data.point_x[31], s_data.point_x});
                        a_reg[1] <= $signed({s_data.seg_start_y[31], s_data.seg_start_y})
                                  - $signed({s_data.point_y[31], s_data.point_y});
                        a_reg[2] <= $signed({s_data.seg_start_z[31], s_data.seg_start_z})
                                  - $signed({s_data.point_z[31], s_data.point_z});
                        b_reg[0] <= $signed({s_data.seg_end_x[31], s_data.seg_end_x})
                                  - $signed({s_data.point_x[31], s_data.point_x});
                        b_reg[1] <= $signed({s_data.seg_end_y[31], s_data.seg_end_y})
                                  - $signed({s_data.point_y[31], s_data.point_y});
                        b_reg[2] <= $signed({s_data.seg_end_z[31], s_data.seg_end_z})
                                  - $signed({s_data.point_z[31], s_data.point_z});
                        state_reg <= s_data.excluded ? F_PUSH : F_MAX;
                    end
                end
                F_MAX: begin
                    m_reg     <= max_all;
                    s_reg     <= '0;
                    state_reg <= F_NORM;
                end
                F_NORM: begin
                    if (m_reg >= bsss_pkg::DiffW'(bsss_pkg::NormLimit)) begin
                        m_reg <= m_reg >> 1;
                        s_reg <= s_reg + 1'b1;
                    end else begin
                        state_reg <= F_SCALE;
                    end
                end
                F_SCALE: begin
                    for (int k = 0; k < 3; k++) begin
                        an_reg[k] <= a_reg[k][bsss_pkg::DiffW-1] ?
                                     -bsss_pkg::NormW'(mag_a[k] >> s_reg) :
                                      bsss_pkg::NormW'(mag_a[k] >> s_reg);
                        bn_reg[k] <= b_reg[k][bsss_pkg::DiffW-1] ?
                                     -bsss_pkg::NormW'(mag_b[k] >> s_reg) :
                                      bsss_pkg::NormW'(mag_b[k] >> s_reg);
                    end
                    sqa_reg   <= '0;
                    sqb_reg   <= '0;
                    dot_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= F_PROD;
                end
                F_PROD: begin
                    sqa_reg <= sqa_reg + bsss_pkg::SqW'(sq_a);
                    sqb_reg <= sqb_reg + bsss_pkg::SqW'(sq_b);
                    dot_reg <= dot_reg + bsss_pkg::DotW'(ab_prod);
                    if (k_idx == 2'd2) begin
                        cnt_reg   <= '0;
                        state_reg <= F_CROSS;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                F_CROSS: begin
                    cr_reg[k_idx] <= bsss_pkg::CrossW'(cr_diff);
                    if (k_idx == 2'd2) begin
                        p_reg     <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= 4'(bsss_pkg::RootW - 1);
                        state_reg <= F_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                F_SQRT: begin
                    if (tp_sq <= sqa_reg) p_reg <= trial_p;
                    if (tq_sq <= sqb_reg) q_reg <= trial_q;
                    if (cnt_reg == '0) state_reg <= F_DEN;
                    else               cnt_reg <= cnt_reg - 1'b1;
                end
                F_DEN: begin
                    pq_reg    <= p_reg * q_reg;
                    psum_reg  <= {1'b0, p_reg} + {1'b0, q_reg};
                    state_reg <= F_DEN2;
                end
                F_DEN2: begin
                    zero_reg <= zero_det;
                    d_reg    <= pq_reg * e_val[bsss_pkg::DotW-1:0];
                    cnt_reg  <= '0;
                    state_reg <= zero_det ? F_PUSH : F_NUM;
                end
                F_NUM: begin
                    n_reg[k_idx]   <= psum_reg * cr_mag;
                    neg_reg[k_idx] <= cr_reg[k_idx][bsss_pkg::CrossW-1];
                    if (k_idx == 2'd2) state_reg <= F_PUSH;
                    else               cnt_reg <= cnt_reg + 1'b1;
                end
                F_PUSH: begin
                    if (!q_full) state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    always_comb begin
        q_data.excl = excl_reg;
        q_data.last = last_reg;
        q_data.zero = zero_reg;
        q_data.s    = s_reg;
        q_data.d    = d_reg;
        q_data.n    = n_reg;
        q_data.neg  = neg_reg;
    end

endmodule

FILE: src/bsss_queue.sv
// ----------------------------------------------------------------------------
// bsss_queue: small job queue
// register fifo between the geometry front and the summing back
// ----------------------------------------------------------------------------
module bsss_queue #(
    parameter int DEPTH = bsss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bsss_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output bsss_pkg::job_t pop_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    bsss_pkg::job_t    mem_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg;

    assign full     = (count_reg == CntW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: src/bsss_back.sv
// ----------------------------------------------------------------------------
// bsss_back: coefficient scaling, division and accumulation
// multiplies the numerators by the coefficient, divides all three by the
// shared denominator one bit a cycle, clamps, sums and emits on last
// ----------------------------------------------------------------------------
module bsss_back #(
    parameter int COORD_FRAC_BITS = bsss_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [bsss_pkg::MantW-1:0]      coeff_mantissa,
    input  logic [bsss_pkg::CoeffShW-1:0]   coeff_shift,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  bsss_pkg::job_t                  q_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output bsss_pkg::out_t                  m_data
);

    localparam int ShBase = bsss_pkg::GuardBits + bsss_pkg::MantW - 2 * COORD_FRAC_BITS;
    localparam logic [bsss_pkg::AccW-1:0] AccMax = bsss_pkg::AccW'(1) << 62;
    localparam logic [bsss_pkg::DivW-1:0] ContribMax = bsss_pkg::DivW'(1) << 40;
    localparam logic signed [bsss_pkg::AccW-1:0] OutMax = 64'sd2147483647;
    localparam logic signed [bsss_pkg::AccW-1:0] OutMin = -64'sd2147483648;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_MUL   = 3'd1;
    localparam logic [2:0] B_MACC  = 3'd2;
    localparam logic [2:0] B_DINIT = 3'd3;
    localparam logic [2:0] B_DIV   = 3'd4;
    localparam logic [2:0] B_SCALE = 3'd5;
    localparam logic [2:0] B_ACC   = 3'd6;
    localparam logic [2:0] B_EMIT  = 3'd7;

    logic [2:0]                            state_reg;
    bsss_pkg::job_t                        job_reg;
    logic [1:0]                            idx_reg;
    logic                                  phase_reg;
    logic [6:0]                            dcnt_reg;
    logic [2*bsss_pkg::MantW-1:0]          prod_reg;
    logic [bsss_pkg::ProdW-1:0]            x_reg [3];
    logic [bsss_pkg::DivW-1:0]             num_reg [3];
    logic [bsss_pkg::DenW-1:0]             rem_reg [3];
    logic signed [bsss_pkg::ContribW-1:0]  contrib_reg [3];
    logic signed [bsss_pkg::AccW-1:0]      acc_reg [3];
    logic                                  flag_reg;
    logic                                  out_valid_reg;
    bsss_pkg::out_t                        out_reg;

    logic [bsss_pkg::MantW-1:0]            mul_op;
    logic [bsss_pkg::DenW:0]               trial [3];
    logic                                  ge [3];
    logic [bsss_pkg::ShW-1:0]              sh;
    logic [bsss_pkg::DivW-1:0]             w [3];
    logic                                  csat [3];
    logic signed [bsss_pkg::AccW:0]        sum [3];
    logic                                  asat_hi [3], asat_lo [3];
    logic                                  out_free;
    logic signed [bsss_pkg::CoordW-1:0]    vel [3];
    logic                                  esat [3];

    assign q_pop    = (state_reg == B_IDLE) && q_valid;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    // coefficient times one half of a numerator
    assign mul_op = phase_reg ? bsss_pkg::MantW'(job_reg.n[idx_reg][bsss_pkg::NumW-1:32])
                              : job_reg.n[idx_reg][31:0];

    // restoring divide step, final shift and clamps
    always_comb begin
        sh = bsss_pkg::ShW'(ShBase) + bsss_pkg::ShW'(coeff_shift) + bsss_pkg::ShW'(job_reg.s);
        for (int k = 0; k < 3; k++) begin
            trial[k] = {rem_reg[k], num_reg[k][bsss_pkg::DivW-1]};
            ge[k]    = trial[k] >= {1'b0, job_reg.d};
            w[k]     = sh[bsss_pkg::ShW-1:7] != '0 ? '0 : num_reg[k] >> sh[6:0];
            csat[k]  = w[k] > ContribMax;
            sum[k]   = (bsss_pkg::AccW+1)'(acc_reg[k]) + (bsss_pkg::AccW+1)'(contrib_reg[k]);
            asat_hi[k] = sum[k] > $signed({1'b0, AccMax});
            asat_lo[k] = sum[k] < -$signed({1'b0, AccMax});
            esat[k]  = (acc_reg[k] > OutMax) || (acc_reg[k] < OutMin);
            vel[k]   = (acc_reg[k] > OutMax) ? bsss_pkg::CoordW'(OutMax) :
                       (acc_reg[k] < OutMin) ? bsss_pkg::CoordW'(OutMin) :
                                               bsss_pkg::CoordW'(acc_reg[k]);
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == B_EMIT) && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // sequencer and accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            flag_reg      <= 1'b0;
            for (int k = 0; k < 3; k++) acc_reg[k] <= '0;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    if (q_valid) begin
                        job_reg   <= q_data;
                        idx_reg   <= '0;
                        phase_reg <= 1'b0;
                        for (int k = 0; k < 3; k++) x_reg[k] <= '0;
                        if (q_data.excl || q_data.zero) begin
                            if (!q_data.excl) flag_reg <= 1'b1;
                            state_reg <= q_data.last ? B_EMIT : B_IDLE;
                        end else begin
                            state_reg <= B_MUL;
                        end
                    end
                end
                B_MUL: begin
                    prod_reg  <= coeff_mantissa * mul_op;
                    state_reg <= B_MACC;
                end
                B_MACC: begin
                    x_reg[idx_reg] <= x_reg[idx_reg] + (phase_reg ?
                                      (bsss_pkg::ProdW'(prod_reg) << 32) : bsss_pkg::ProdW'(prod_reg));
                    phase_reg <= !phase_reg;
                    if (!phase_reg) begin
                        state_reg <= B_MUL;
                    end else if (idx_reg == 2'd2) begin
                        state_reg <= B_DINIT;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= B_MUL;
                    end
                end
                B_DINIT: begin
                    for (int k = 0; k < 3; k++) begin
                        num_reg[k] <= bsss_pkg::DivW'({x_reg[k], bsss_pkg::GuardBits'(0)});
                        rem_reg[k] <= '0;
                    end
                    dcnt_reg  <= '0;
                    state_reg <= B_DIV;
                end
                B_DIV: begin
                    for (int k = 0; k < 3; k++) begin
                        rem_reg[k] <= ge[k] ? bsss_pkg::DenW'(trial[k] - {1'b0, job_reg.d})
                                            : bsss_pkg::DenW'(trial[k]);
                        num_reg[k] <= {num_reg[k][bsss_pkg::DivW-2:0], ge[k]};
                    end
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 7'(bsss_pkg::DivW - 1)) state_reg <= B_SCALE;
                end
                B_SCALE: begin
                    for (int k = 0; k < 3; k++) begin
                        if (job_reg.neg[k])
                            contrib_reg[k] <= csat[k] ? -bsss_pkg::ContribW'(ContribMax)
                                                      : -bsss_pkg::ContribW'(w[k]);
                        else
                            contrib_reg[k] <= csat[k] ? bsss_pkg::ContribW'(ContribMax)
                                                      : bsss_pkg::ContribW'(w[k]);
                    end
                    if (csat[0] || csat[1] || csat[2]) flag_reg <= 1'b1;
                    state_reg <= B_ACC;
                end
                B_ACC: begin
                    for (int k = 0; k < 3; k++) begin
                        if (asat_hi[k])      acc_reg[k] <= $signed(AccMax);
                        else if (asat_lo[k]) acc_reg[k] <= -$signed(AccMax);
                        else                 acc_reg[k] <= bsss_pkg::AccW'(sum[k]);
                    end
                    if (asat_hi[0] || asat_hi[1] || asat_hi[2] ||
                        asat_lo[0] || asat_lo[1] || asat_lo[2])
                        flag_reg <= 1'b1;
                    state_reg <= job_reg.last ? B_EMIT : B_IDLE;
                end
                B_EMIT: begin
                    if (out_free) begin
                        out_reg.vel_x    <= vel[0];
                        out_reg.vel_y    <= vel[1];
                        out_reg.vel_z    <= vel[2];
                        out_reg.overflow <= flag_reg || esat[0] || esat[1] || esat[2];
                        flag_reg         <= 1'b0;
                        for (int k = 0; k < 3; k++) acc_reg[k] <= '0;
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

FILE: src/biot_savart_segment_sum_unit.sv
// The front normalizes with a shift loop, takes a 15-step root and forms the
// products; the back runs 6 multiply steps, a 128-step shared-divisor divide,
// scale and add, and takes a new segment only once done with the last one;
// the job queue lets the front prepare the next segment meanwhile.
// Reset: synchronous active low; clears accumulators, flag, queue, state, config.
// ----------------------------------------------------------------------------
// biot_savart_segment_sum_unit: streaming segment velocity sum
// front geometry sequencer, job queue and back divide/accumulate engine
// ----------------------------------------------------------------------------
module biot_savart_segment_sum_unit #(
    parameter int COORD_FRAC_BITS = bsss_pkg::COORD_FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH     = bsss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bsss_pkg::CfgAddrW-1:0]  cfg_addr,
    input  logic [bsss_pkg::MantW-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  bsss_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output bsss_pkg::out_t                 m_data
);

    logic [bsss_pkg::MantW-1:0]    mant_reg;
    logic [bsss_pkg::CoeffShW-1:0] shift_reg;
    logic                          q_push, q_full, q_pop, q_valid;
    bsss_pkg::job_t                q_in, q_out;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mant_reg  <= '0;
            shift_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bsss_pkg::CFG_COEFF_MANTISSA: mant_reg  <= cfg_wdata;
                bsss_pkg::CFG_COEFF_SHIFT:    shift_reg <= cfg_wdata[bsss_pkg::CoeffShW-1:0];
                default: ;
            endcase
        end
    end

    bsss_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_data  (q_in)
    );

    bsss_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    bsss_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .coeff_mantissa (mant_reg),
        .coeff_shift    (shift_reg),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_data         (q_out),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

FILE: src/bsss_checker.sv
// ----------------------------------------------------------------------------
// bsss_checker: port level checks for the segment velocity sum
// watches the request and result channels of the top level
// ----------------------------------------------------------------------------
module bsss_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input bsss_pkg::out_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // front takes one request at a time
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while front busy");

    // reset leaves no result pending
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // reset leaves the front ready
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("front not ready after reset");

endmodule

bind biot_savart_segment_sum_unit bsss_checker u_bsss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
